FILE: src/ewma_volatility_estimator_macros.svh
// Assertion macros shared by the EWMA volatility estimator checker.
// No dependencies; included by the files that assert.
`ifndef EWMA_VOLATILITY_ESTIMATOR_MACROS_SVH
`define EWMA_VOLATILITY_ESTIMATOR_MACROS_SVH

// Property checked while reset is released.
`define EWMAV_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define EWMAV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ewmav_pkg.sv
// Shared types and constants of the EWMA volatility estimator.
// No dependencies; used by every module of the block.
`default_nettype none

package ewmav_pkg;

    localparam int unsigned QueueDepth = 4;

    localparam int unsigned CfgIndexWidth = 3;
    localparam logic [CfgIndexWidth-1:0] CFG_DECAY_LAMBDA = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_ANNUALIZE    = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_ANNUAL_SCALE = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_MIN_VOL      = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_VOL      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;

    localparam logic [16:0] LAMBDA_ONE       = 17'd65536;
    localparam logic [16:0] LAMBDA_RESET     = 17'd61604;
    localparam logic        ANNUALIZE_RESET  = 1'b1;
    localparam logic [23:0] SCALE_RESET      = 24'd1040358;
    localparam logic [31:0] MIN_VOL_RESET    = 32'd655;
    localparam logic [31:0] MAX_VOL_RESET    = 32'd327680;
    localparam logic [29:0] LN2_Q30          = 30'd744261118;

    typedef struct packed {
        logic [31:0] price;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] volatility;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [31:0] price;
        logic        last;
        logic        zero;
    } q_item_t;

    typedef struct packed {
        logic [16:0] lambda;
        logic        annualize;
        logic [23:0] scale;
        logic [31:0] min_vol;
        logic [31:0] max_vol;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/ewmav_front.sv
// Front end: accepts price requests, marks zero prices and queues them.
// Depends on ewmav_pkg.
`default_nettype none

module ewmav_front #(
    parameter int unsigned DEPTH = ewmav_pkg::QueueDepth
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  ewmav_pkg::in_item_t    s_data,
    output logic                   q_valid,
    input  wire                    q_ready,
    output ewmav_pkg::q_item_t     q_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ewmav_pkg::q_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign s_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{price: s_data.price, last: s_data.last,
                                     zero: (s_data.price == '0)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/ewmav_back.sv
// Back end: log return, EWMA variance update, square root, scaling and clamp.
// Depends on ewmav_pkg; fed by ewmav_front.
`default_nettype none

module ewmav_back (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  ewmav_pkg::cfg_t        cfg,
    input  wire                    q_valid,
    output logic                   q_ready,
    input  ewmav_pkg::q_item_t     q_item,
    output logic                   m_valid,
    input  wire                    m_ready,
    output ewmav_pkg::out_item_t   m_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_SQ0   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_RET   = 4'd4;
    localparam logic [3:0] S_RSQ   = 4'd5;
    localparam logic [3:0] S_EW1   = 4'd6;
    localparam logic [3:0] S_EW2   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_ROOT  = 4'd9;
    localparam logic [3:0] S_SCALE = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  state_reg;
    ewmav_pkg::q_item_t item_reg;
    logic [31:0] m_reg;
    logic [4:0]  k_reg;
    logic [2:0]  step_reg;
    logic [4:0]  it_reg;
    logic [29:0] frac_reg;
    logic [63:0] p_reg;
    logic        neg_reg;
    logic [34:0] lprev_reg;
    logic        prev_nz_reg;
    logic [1:0]  cnt_reg;
    logic        zero_seen_reg;
    logic [63:0] var_reg;
    logic [63:0] hi_reg;
    logic [18:0] lo_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [63:0] bit_reg;
    logic [31:0] vol_reg;
    logic [1:0]  status_reg;
    ewmav_pkg::out_item_t out_reg;
    logic        m_valid_reg;

    logic [34:0] lcur;
    logic [35:0] diff, dmag;
    logic        dneg;
    logic [33:0] dclamp;
    logic [32:0] sq;
    logic        sq_bit;
    logic [31:0] m_n;
    logic [64:0] rsum;
    logic [32:0] r_raw;
    logic [31:0] rmag;
    logic [16:0] lam_sat, w;
    logic [34:0] lo_sum;
    logic [63:0] hi_prod, ew_sum;
    logic [63:0] trial;
    logic [56:0] sprod;
    logic [32:0] vraw;
    logic [31:0] v1, vol_cl;
    logic [1:0]  cnt_inc;

    // The log2 integer part k-16 in five-bit two's complement is k with its top bit flipped.
    assign lcur   = {k_reg ^ 5'd16, frac_reg};
    assign diff   = {lcur[34], lcur} - {lprev_reg[34], lprev_reg};
    assign dneg   = diff[35];
    assign dmag   = dneg ? (36'd0 - diff) : diff;
    assign dclamp = (dmag[35:34] != 2'b00) ? '1 : dmag[33:0];

    assign sq     = p_reg[63:31];
    assign sq_bit = sq[32];
    assign m_n    = sq_bit ? sq[32:1] : sq[31:0];

    assign rsum  = {1'b0, p_reg} + 65'h0_8000_0000;
    assign r_raw = rsum[64:32];
    always_comb begin
        if (neg_reg) begin
            rmag = (r_raw > 33'h0_8000_0000) ? 32'h8000_0000 : r_raw[31:0];
        end else begin
            rmag = (r_raw > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_raw[31:0];
        end
    end

    assign lam_sat = (cfg.lambda > ewmav_pkg::LAMBDA_ONE) ? ewmav_pkg::LAMBDA_ONE : cfg.lambda;
    assign w       = ewmav_pkg::LAMBDA_ONE - lam_sat;
    assign lo_sum  = 35'(lam_sat) * 35'(var_reg[15:0]) + 35'(w) * 35'(p_reg[15:0])
                   + 35'h8000;
    assign hi_prod = 64'(lam_sat) * 64'(var_reg[63:16]);
    assign ew_sum  = hi_reg + 64'(w) * 64'(p_reg[63:16]) + 64'(lo_reg);

    assign trial = root_reg + bit_reg;

    assign sprod = 57'(root_reg[31:0]) * 57'(cfg.scale) + 57'h800_0000;
    assign vraw  = 33'(root_reg[31:0]) + 33'h800;

    assign v1     = (vol_reg < cfg.min_vol) ? cfg.min_vol : vol_reg;
    assign vol_cl = (v1 > cfg.max_vol) ? cfg.max_vol : v1;

    assign cnt_inc = (cnt_reg == 2'd2) ? 2'd2 : cnt_reg + 2'd1;

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            zero_seen_reg <= 1'b0;
            prev_nz_reg   <= 1'b0;
            var_reg       <= '0;
        end else begin
            // In S_OUT the result register is reloaded below instead.
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_item;
                        if (q_item.zero) begin
                            zero_seen_reg <= 1'b1;
                            state_reg     <= S_FIN;
                        end else begin
                            m_reg     <= q_item.price;
                            k_reg     <= 5'd31;
                            step_reg  <= '0;
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // Binary search for the leading one, one shift width per cycle.
                    step_reg <= step_reg + 3'd1;
                    case (step_reg)
                        3'd0: if (m_reg[31:16] == '0) begin
                            m_reg <= {m_reg[15:0], 16'd0};
                            k_reg <= k_reg - 5'd16;
                        end
                        3'd1: if (m_reg[31:24] == '0) begin
                            m_reg <= {m_reg[23:0], 8'd0};
                            k_reg <= k_reg - 5'd8;
                        end
                        3'd2: if (m_reg[31:28] == '0) begin
                            m_reg <= {m_reg[27:0], 4'd0};
                            k_reg <= k_reg - 5'd4;
                        end
                        3'd3: if (m_reg[31:30] == '0) begin
                            m_reg <= {m_reg[29:0], 2'd0};
                            k_reg <= k_reg - 5'd2;
                        end
                        default: begin
                            if (!m_reg[31]) begin
                                m_reg <= {m_reg[30:0], 1'b0};
                                k_reg <= k_reg - 5'd1;
                            end
                            state_reg <= S_SQ0;
                        end
                    endcase
                end
                S_SQ0: begin
                    p_reg     <= 64'(m_reg) * 64'(m_reg);
                    it_reg    <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    // Each squaring yields one fraction bit of log2.
                    frac_reg <= {frac_reg[28:0], sq_bit};
                    p_reg    <= 64'(m_n) * 64'(m_n);
                    it_reg   <= it_reg + 5'd1;
                    if (it_reg == 5'd29) begin
                        state_reg <= (cnt_reg != 2'd0 && prev_nz_reg) ? S_RET : S_FIN;
                    end
                end
                S_RET: begin
                    p_reg     <= 64'(dclamp) * 64'(ewmav_pkg::LN2_Q30);
                    neg_reg   <= dneg;
                    state_reg <= S_RSQ;
                end
                S_RSQ: begin
                    p_reg     <= 64'(rmag) * 64'(rmag);
                    state_reg <= S_EW1;
                end
                S_EW1: begin
                    if (cnt_reg == 2'd1) begin
                        var_reg   <= p_reg;
                        state_reg <= S_FIN;
                    end else begin
                        hi_reg    <= hi_prod;
                        lo_reg    <= lo_sum[34:16];
                        state_reg <= S_EW2;
                    end
                end
                S_EW2: begin
                    var_reg   <= ew_sum;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    cnt_reg     <= cnt_inc;
                    prev_nz_reg <= !item_reg.zero;
                    lprev_reg   <= lcur;
                    if (!item_reg.last) begin
                        state_reg <= S_IDLE;
                    end else if (cnt_inc != 2'd2) begin
                        status_reg <= ewmav_pkg::STATUS_SHORT;
                        state_reg  <= S_OUT;
                    end else if (zero_seen_reg) begin
                        status_reg <= ewmav_pkg::STATUS_ZERO;
                        state_reg  <= S_OUT;
                    end else begin
                        status_reg <= ewmav_pkg::STATUS_OK;
                        rem_reg    <= var_reg;
                        root_reg   <= '0;
                        bit_reg    <= 64'h4000_0000_0000_0000;
                        state_reg  <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (rem_reg >= trial) begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    vol_reg   <= cfg.annualize ? 32'(sprod[56:28]) : 32'(vraw[32:12]);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.status     <= status_reg;
                        out_reg.volatility <= (status_reg == ewmav_pkg::STATUS_OK) ?
                                              vol_cl : 32'd0;
                        m_valid_reg   <= 1'b1;
                        cnt_reg       <= '0;
                        zero_seen_reg <= 1'b0;
                        prev_nz_reg   <= 1'b0;
                        var_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/ewma_volatility_estimator.sv
// Top level of the EWMA volatility estimator: configuration registers,
// front end queue and back end datapath. Depends on ewmav_pkg, ewmav_front, ewmav_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    price, last
//   m_        out        m_valid/m_ready    volatility, status
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// A nonzero price passes through the 30 serial squarings of the log2 unit in
// the back end; a zero price skips them. A last item adds the output step,
// preceded by the bit-serial square root and scaling when the status is OK.
// The input queue keeps accepting requests while the back end works or a result
// waits, as long as it is not full. Reset is synchronous, clears all control
// state and reloads the configuration defaults.
`default_nettype none

module ewma_volatility_estimator #(
    parameter int unsigned QUEUE_DEPTH = ewmav_pkg::QueueDepth
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  ewmav_pkg::in_item_t                      s_data,
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output ewmav_pkg::out_item_t                     m_data,
    input  wire                                      cfg_we,
    input  wire [ewmav_pkg::CfgIndexWidth-1:0]       cfg_index,
    input  wire [31:0]                               cfg_wdata
);

    ewmav_pkg::cfg_t    cfg_reg;
    ewmav_pkg::q_item_t q_item;
    logic               q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lambda    <= ewmav_pkg::LAMBDA_RESET;
            cfg_reg.annualize <= ewmav_pkg::ANNUALIZE_RESET;
            cfg_reg.scale     <= ewmav_pkg::SCALE_RESET;
            cfg_reg.min_vol   <= ewmav_pkg::MIN_VOL_RESET;
            cfg_reg.max_vol   <= ewmav_pkg::MAX_VOL_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ewmav_pkg::CFG_DECAY_LAMBDA: cfg_reg.lambda    <= cfg_wdata[16:0];
                ewmav_pkg::CFG_ANNUALIZE:    cfg_reg.annualize <= cfg_wdata[0];
                ewmav_pkg::CFG_ANNUAL_SCALE: cfg_reg.scale     <= cfg_wdata[23:0];
                ewmav_pkg::CFG_MIN_VOL:      cfg_reg.min_vol   <= cfg_wdata;
                ewmav_pkg::CFG_MAX_VOL:      cfg_reg.max_vol   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ewmav_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    ewmav_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: src/ewmav_checker.sv
// Port-level checker for the EWMA volatility estimator, bound to the top level.
// Depends on ewmav_pkg and ewma_volatility_estimator_macros.svh.
`default_nettype none
`include "ewma_volatility_estimator_macros.svh"

module ewmav_checker (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   m_valid,
    input wire                   m_ready,
    input ewmav_pkg::out_item_t  m_data
);

    `EWMAV_ASSERT_ALWAYS(a_no_result_after_reset, aclk, !aresetn |=> !m_valid, "result after reset")
    `EWMAV_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")
    `EWMAV_ASSERT(a_error_zero, aclk, aresetn, m_valid && m_data.status != ewmav_pkg::STATUS_OK |-> m_data.volatility == 32'd0, "error result with nonzero volatility")

endmodule

bind ewma_volatility_estimator ewmav_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

FILE: tb/sv/ewma_volatility_estimator_checker.sv
// Checker for the EWMA volatility estimator: watches the request, result and configuration
// channels, predicts each series result and compares it field by field. Depends on ewmav_pkg.
`timescale 1ns / 1ps

module ewma_volatility_estimator_checker (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    input  wire                  s_ready,
    input  ewmav_pkg::in_item_t  s_data,
    input  wire                  m_valid,
    input  wire                  m_ready,
    input  ewmav_pkg::out_item_t m_data,
    input  wire                  cfg_we,
    input  wire [ewmav_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire [31:0]           cfg_wdata,
    output int                   fail_count,
    output int                   pending_count
);
    import ewmav_pkg::*;

    cfg_t            cfg;
    logic [31:0]     prev_price;
    logic [63:0]     variance;
    logic [1:0]      price_cnt;
    logic            zero_seen;
    out_item_t       vol_queue[$];

    // log2(x / 65536) in signed Q.30, by normalising and repeated squaring.
    function automatic longint log2_fix(input logic [31:0] x);
        int          k;
        logic [63:0] m;
        longint      frac;
        k = 31;
        frac = 0;
        while (k > 0 && x[k] == 1'b0) k--;
        m = 64'(x) << (31 - k);
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) - 16) * (longint'(1) << 30) + frac;
    endfunction

    // Magnitude of ln(p/q) in Q4.28 after rounding and saturation.
    function automatic logic [63:0] return_mag(input logic [31:0] p, input logic [31:0] q);
        longint      d;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] r;
        d = log2_fix(p) - log2_fix(q);
        neg = d < 0;
        mag = neg ? 64'(-d) : 64'(d);
        if (mag > (64'd1 << 34) - 1) mag = (64'd1 << 34) - 1;
        r = (mag * 64'd744261118 + (64'd1 << 31)) >> 32;
        if (neg) begin
            if (r > 64'h8000_0000) r = 64'h8000_0000;
        end else if (r > 64'h7FFF_FFFF) begin
            r = 64'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic predict_price(input in_item_t it);
        logic [63:0] r2, a, w, s, vol;
        out_item_t   res;
        if (it.price == 0) zero_seen = 1'b1;
        if (price_cnt >= 1 && it.price != 0 && prev_price != 0) begin
            r2 = return_mag(it.price, prev_price);
            r2 = r2 * r2;
            if (price_cnt == 1) begin
                variance = r2;
            end else begin
                a = (cfg.lambda > LAMBDA_ONE) ? 64'(LAMBDA_ONE) : 64'(cfg.lambda);
                w = 64'd65536 - a;
                variance = a * (variance >> 16) + w * (r2 >> 16)
                    + ((a * (variance & 64'hFFFF) + w * (r2 & 64'hFFFF) + 64'h8000) >> 16);
            end
        end
        prev_price = it.price;
        if (price_cnt < 2) price_cnt++;
        if (!it.last) return;
        if (price_cnt < 2) begin
            res.status = STATUS_SHORT;
            res.volatility = '0;
        end else if (zero_seen) begin
            res.status = STATUS_ZERO;
            res.volatility = '0;
        end else begin
            s = floor_sqrt(variance);
            if (cfg.annualize) vol = (s * 64'(cfg.scale) + (64'd1 << 27)) >> 28;
            else vol = (s + 64'h800) >> 12;
            if (vol < 64'(cfg.min_vol)) vol = 64'(cfg.min_vol);
            if (vol > 64'(cfg.max_vol)) vol = 64'(cfg.max_vol);
            res.status = STATUS_OK;
            res.volatility = vol[31:0];
        end
        vol_queue.push_back(res);
        prev_price = '0;
        variance = '0;
        price_cnt = '0;
        zero_seen = 1'b0;
    endtask

    always @(posedge aclk) begin
        out_item_t exp_res;
        if (!aresetn) begin
            cfg <= '{LAMBDA_RESET, ANNUALIZE_RESET, SCALE_RESET, MIN_VOL_RESET, MAX_VOL_RESET};
            prev_price = '0;
            variance = '0;
            price_cnt = '0;
            zero_seen = 1'b0;
            vol_queue.delete();
            fail_count <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DECAY_LAMBDA: cfg.lambda <= cfg_wdata[16:0];
                    CFG_ANNUALIZE:    cfg.annualize <= cfg_wdata[0];
                    CFG_ANNUAL_SCALE: cfg.scale <= cfg_wdata[23:0];
                    CFG_MIN_VOL:      cfg.min_vol <= cfg_wdata;
                    CFG_MAX_VOL:      cfg.max_vol <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_price(s_data);
            if (m_valid && m_ready) begin
                if (vol_queue.size() == 0) begin
                    $display("%0t: unexpected result vol=%0d status=%0d",
                             $time, m_data.volatility, m_data.status);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_res = vol_queue.pop_front();
                    if (exp_res.volatility !== m_data.volatility ||
                        exp_res.status !== m_data.status) begin
                        $display("%0t: mismatch vol exp %0d got %0d, status exp %0d got %0d",
                                 $time, exp_res.volatility, m_data.volatility,
                                 exp_res.status, m_data.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= vol_queue.size();
        end
    end
endmodule

FILE: tb/sv/ewma_volatility_estimator_tb.sv
// Top of the EWMA volatility estimator testbench: clock, reset, stimulus and verdict.
// Depends on ewmav_pkg, the block and ewma_volatility_estimator_checker.
`timescale 1ns / 1ps

module ewma_volatility_estimator_tb;
    import ewmav_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    int          fail_count;
    int          pending_count;
    longint      cycle_count = 0;
    bit          quiet_tail = 0;
    bit          long_hold = 0;

    always #6 aclk = ~aclk;

    ewma_volatility_estimator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    ewma_volatility_estimator_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("ewma_volatility_estimator_tb: FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 0;
            end
            n = $urandom_range(1, 12);
            m_ready <= quiet_tail || ($urandom_range(0, 2) != 0);
            repeat (n) @(posedge aclk);
        end
    end

    // Valid stays high after an acceptance so that requests can follow back to back;
    // it drops only for an idle burst or when the sender pauses.
    task automatic send_price(input logic [31:0] p, input logic l);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{price: p, last: l};
        @(posedge aclk iff s_ready);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits for all results, then for the back end to finish any trailing price.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // Mostly prices near a base so returns stay realistic, sometimes wild values.
    function automatic logic [31:0] rand_price(input logic [31:0] base);
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return base + $urandom_range(0, base >> 5) - (base >> 6);
        endcase
    endfunction

    task automatic random_series(input int n);
        logic [31:0] base;
        base = 32'd1 << $urandom_range(8, 28);
        base = base | ($urandom & (base - 1));
        for (int i = 0; i < n; i++) send_price(rand_price(base), i == n - 1);
    endtask

    initial begin
        int sent;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes and special cases at reset configuration.
        send_price(32'h0001_0000, 1'b1);                 // one price only
        send_price(32'h0000_0000, 1'b1);                 // lone zero
        send_price(32'h0001_0000, 1'b0);
        send_price(32'h0000_0000, 1'b0);
        send_price(32'h0001_0000, 1'b1);                 // zero inside series
        send_price(32'h0000_0001, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b1);                 // largest rise
        send_price(32'hFFFF_FFFF, 1'b0);
        send_price(32'h0000_0001, 1'b0);                 // largest fall
        send_price(32'hAAAA_5555, 1'b1);
        send_price(32'h0064_0000, 1'b0);
        send_price(32'h0064_0000, 1'b0);
        send_price(32'h0064_0000, 1'b1);                 // flat: clamp to min
        drain();

        // Lambda above one, no annualising, crossed clamps.
        write_reg(CFG_DECAY_LAMBDA, 32'h1FFFF);
        write_reg(CFG_ANNUALIZE, 32'd0);
        write_reg(CFG_MIN_VOL, 32'd500000);
        write_reg(CFG_MAX_VOL, 32'd1000);
        random_series(4);
        random_series(3);
        drain();
        write_reg(CFG_DECAY_LAMBDA, 32'd0);
        write_reg(CFG_ANNUAL_SCALE, 32'hFFFFFF);
        write_reg(CFG_ANNUALIZE, 32'd1);
        write_reg(CFG_MIN_VOL, 32'd0);
        write_reg(CFG_MAX_VOL, 32'hFFFF_FFFF);
        random_series(3);
        send_price(32'h0000_0001, 1'b0);
        send_price(32'hFFFF_FFFF, 1'b1);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        long_hold = 1;
        for (int i = 0; i < 20; i++) random_series(2);
        drain();

        sent = 0;
        while (sent < 1900) begin
            int n;
            if ($urandom_range(0, 9) == 0) begin
                drain();
                write_reg(CfgIndexWidth'($urandom_range(0, 4)),
                          $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
                write_reg(CFG_MIN_VOL, $urandom_range(0, 2000));
                write_reg(CFG_MAX_VOL, $urandom_range(0, 3) == 0 ? $urandom
                                                                  : 32'hFFFF_FFFF);
                write_reg(CFG_ANNUAL_SCALE, $urandom & 32'hFFFFFF);
                write_reg(CFG_DECAY_LAMBDA, $urandom_range(0, 65536));
                write_reg(CFG_ANNUALIZE, $urandom_range(0, 1));
            end
            if (sent > 1700) quiet_tail = 1;
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            random_series(n);
            sent += n;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ewma_volatility_estimator_tb: PASS");
        end else begin
            $display("ewma_volatility_estimator_tb: FAIL");
        end
        $finish;
    end
endmodule
